### sv/adps_pkg.sv
// shared types and constants of the adc to pwm duty smoother
package adps_pkg;

	// field widths
	localparam int SAMPLE_W = 10;
	localparam int DUTY_W   = 8;
	localparam int THR_W    = 8;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [DUTY_W-1:0]   duty_t;
	typedef logic [THR_W-1:0]    thr_t;

	// hysteresis threshold after reset
	localparam thr_t THR_RESET = thr_t'(2);

	// filter: floor((avg + 4*s) / 5) as multiply by reciprocal and shift
	localparam int         SMOOTH_NUM_W = SAMPLE_W + 3;
	localparam int         SMOOTH_SHIFT = 16;
	localparam int         SMOOTH_REC_W = 14;
	localparam logic [SMOOTH_REC_W-1:0] SMOOTH_REC = 14'd13108;

	// duty map: floor((s*255 + 511) / 1023) as multiply by reciprocal and shift
	localparam int         DUTY_NUM_W = SAMPLE_W + DUTY_W;
	localparam logic [DUTY_NUM_W-1:0] DUTY_ROUND = 18'd511;
	localparam int         DUTY_SHIFT = 28;
	localparam int         DUTY_REC_W = 19;
	localparam logic [DUTY_REC_W-1:0] DUTY_REC = 19'd262401;

	// extreme duty codes that always refresh the held duty
	localparam duty_t DUTY_MIN = duty_t'(0);
	localparam duty_t DUTY_MAX = duty_t'(255);

endpackage

### sv/adps_sample_if.sv
// sample channel: valid, ready and one converter reading
interface adps_sample_if import adps_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

### sv/adps_result_if.sv
// result channel: valid, ready, held duty and update flag
interface adps_result_if import adps_pkg::*; ();
	logic  valid;
	logic  ready;
	duty_t duty;
	logic  changed;

	modport source (output valid, output duty, output changed, input ready);
	modport sink (input valid, input duty, input changed, output ready);
endinterface

### sv/adps_accum.sv
// block accumulator: sums samples and hands over one block total per block
module adps_accum import adps_pkg::*; #(
	parameter int BLOCK_SAMPLES = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	adps_sample_if.sink         samples,
	output logic                sum_valid,
	input  logic                sum_ready,
	output logic [SAMPLE_W+$clog2(BLOCK_SAMPLES)-1:0] sum
);

	localparam int SUM_W = SAMPLE_W + $clog2(BLOCK_SAMPLES);
	localparam int CNT_W = $clog2(BLOCK_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BLOCK_SAMPLES - 1);

	logic [SUM_W-1:0] acc_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_s1;
	logic             valid_s1;
	logic [SUM_W-1:0] total;
	logic             last;
	logic             fire;

	// running total including the offered sample
	assign total = acc_q + SUM_W'(samples.sample);
	assign last  = (count_q == CNT_LAST);

	// only the closing sample of a block needs room in the block register
	assign samples.ready = !last || !valid_s1 || sum_ready;
	assign fire          = samples.valid && samples.ready;

	// accumulator, sample count and block register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (fire && last)
				valid_s1 <= 1'b1;
			else if (sum_ready)
				valid_s1 <= 1'b0;
			if (fire) begin
				if (last) begin
					acc_q   <= '0;
					count_q <= '0;
				end else begin
					acc_q   <= total;
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// block total
	always_ff @(posedge clk) begin
		if (fire && last)
			sum_s1 <= total;
	end

	assign sum_valid = valid_s1;
	assign sum       = sum_s1;

endmodule

### sv/adps_filter.sv
// block average and first-order low-pass filter
module adps_filter import adps_pkg::*; #(
	parameter int BLOCK_SAMPLES = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sum_valid,
	output logic                sum_ready,
	input  logic [SAMPLE_W+$clog2(BLOCK_SAMPLES)-1:0] sum,
	output logic                lvl_valid,
	input  logic                lvl_ready,
	output sample_t             lvl
);

	localparam int SUM_W    = SAMPLE_W + $clog2(BLOCK_SAMPLES);
	localparam int AVG_SH   = SUM_W + $clog2(BLOCK_SAMPLES);
	localparam int AVG_RW   = AVG_SH + 1;
	localparam logic [AVG_RW-1:0] AVG_REC =
		AVG_RW'(((longint'(1) << AVG_SH) + BLOCK_SAMPLES - 1) / BLOCK_SAMPLES);
	localparam int AVG_PW   = SUM_W + AVG_RW;
	localparam int SMOOTH_PW = SMOOTH_NUM_W + SMOOTH_REC_W;

	sample_t                 avg_s2;
	logic                    valid_s2;
	sample_t                 smoothed_q;
	logic                    valid_s3;
	logic                    s2_ready;
	logic                    s3_ready;
	logic [AVG_PW-1:0]       avg_prod;
	logic [SMOOTH_NUM_W-1:0] smooth_num;
	logic [SMOOTH_PW-1:0]    smooth_prod;
	sample_t                 smooth_next;

	// per-stage flow control
	assign s3_ready  = !valid_s3 || lvl_ready;
	assign s2_ready  = !valid_s2 || s3_ready;
	assign sum_ready = s2_ready;

	// block average: floor(sum / BLOCK_SAMPLES) by reciprocal
	assign avg_prod = AVG_PW'(sum) * AVG_PW'(AVG_REC);

	// filter update: floor((avg + 4*smoothed) / 5) by reciprocal
	assign smooth_num  = SMOOTH_NUM_W'(avg_s2) + {1'b0, smoothed_q, 2'b00};
	assign smooth_prod = SMOOTH_PW'(smooth_num) * SMOOTH_PW'(SMOOTH_REC);
	assign smooth_next = smooth_prod[SMOOTH_SHIFT +: SAMPLE_W];

	// stage valids and the filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			smoothed_q <= '0;
		end else begin
			if (s2_ready)
				valid_s2 <= sum_valid;
			if (s3_ready) begin
				valid_s3 <= valid_s2;
				if (valid_s2)
					smoothed_q <= smooth_next;
			end
		end
	end

	// average register
	always_ff @(posedge clk) begin
		if (s2_ready && sum_valid)
			avg_s2 <= avg_prod[AVG_SH +: SAMPLE_W];
	end

	assign lvl_valid = valid_s3;
	assign lvl       = smoothed_q;

endmodule

### sv/adps_duty.sv
// duty mapping, hysteresis decision and result register
module adps_duty import adps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          lvl_valid,
	output logic          lvl_ready,
	input  sample_t       lvl,
	input  thr_t          threshold,
	adps_result_if.source results
);

	localparam int DUTY_PW = DUTY_NUM_W + DUTY_REC_W;

	duty_t                 fresh_s4;
	logic                  valid_s4;
	duty_t                 held_q;
	duty_t                 duty_q;
	logic                  changed_q;
	logic                  valid_q;
	logic                  s4_ready;
	logic                  out_ready;
	logic [DUTY_NUM_W-1:0] duty_num;
	logic [DUTY_PW-1:0]    duty_prod;
	duty_t                 gap;
	logic                  update;

	// per-stage flow control
	assign out_ready = !valid_q || results.ready;
	assign s4_ready  = !valid_s4 || out_ready;
	assign lvl_ready = s4_ready;

	// duty = floor((s*255 + 511) / 1023) by reciprocal
	assign duty_num  = {lvl, {DUTY_W{1'b0}}} - DUTY_NUM_W'(lvl) + DUTY_ROUND;
	assign duty_prod = DUTY_PW'(duty_num) * DUTY_PW'(DUTY_REC);

	// hysteresis: update on a large enough change or at either extreme
	assign gap    = (fresh_s4 >= held_q) ? (fresh_s4 - held_q) : (held_q - fresh_s4);
	assign update = (gap > threshold) || (fresh_s4 == DUTY_MIN) || (fresh_s4 == DUTY_MAX);

	// stage valids and the held duty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_q  <= 1'b0;
			held_q   <= '0;
		end else begin
			if (s4_ready)
				valid_s4 <= lvl_valid;
			if (out_ready) begin
				valid_q <= valid_s4;
				if (valid_s4 && update)
					held_q <= fresh_s4;
			end
		end
	end

	// duty register and result payload
	always_ff @(posedge clk) begin
		if (s4_ready && lvl_valid)
			fresh_s4 <= duty_prod[DUTY_SHIFT +: DUTY_W];
		if (out_ready && valid_s4) begin
			duty_q    <= update ? fresh_s4 : held_q;
			changed_q <= update;
		end
	end

	assign results.valid   = valid_q;
	assign results.duty    = duty_q;
	assign results.changed = changed_q;

endmodule

### sv/adc_to_pwm_duty_smoother.sv
// Converter samples are summed in blocks of BLOCK_SAMPLES; each finished block gives one
// result: the block average drives a low-pass filter of weight 1/5, the filtered level is
// mapped to an 8-bit duty and the held duty follows it only past the hysteresis threshold
// or at 0 and 255. One sample is taken every clock cycle unless a block's closing sample
// is held off; a result passes the five pipeline registers (block total, average, filter
// state, duty, result), each of which stalls only when it is full and the next one cannot
// take it, so samples keep flowing while a result waits until the stall reaches the block
// total. The threshold resets to 2 and should be written only while the block is idle.
module adc_to_pwm_duty_smoother import adps_pkg::*; #(
	parameter int BLOCK_SAMPLES = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	adps_sample_if.sink   samples,
	adps_result_if.source results,
	input  logic          cfg_wr_en,
	input  thr_t          cfg_wr_data
);

	localparam int SUM_W = SAMPLE_W + $clog2(BLOCK_SAMPLES);

	thr_t             threshold_q;
	logic             sum_valid;
	logic             sum_ready;
	logic [SUM_W-1:0] sum;
	logic             lvl_valid;
	logic             lvl_ready;
	sample_t          lvl;

	// hysteresis threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			threshold_q <= THR_RESET;
		else if (cfg_wr_en)
			threshold_q <= cfg_wr_data;
	end

	// block accumulation
	adps_accum #(
		.BLOCK_SAMPLES(BLOCK_SAMPLES)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.sum_valid(sum_valid),
		.sum_ready(sum_ready),
		.sum      (sum)
	);

	// average and filter
	adps_filter #(
		.BLOCK_SAMPLES(BLOCK_SAMPLES)
	) u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.sum_valid(sum_valid),
		.sum_ready(sum_ready),
		.sum      (sum),
		.lvl_valid(lvl_valid),
		.lvl_ready(lvl_ready),
		.lvl      (lvl)
	);

	// duty map and hysteresis
	adps_duty u_duty (
		.clk      (clk),
		.arst_n   (arst_n),
		.lvl_valid(lvl_valid),
		.lvl_ready(lvl_ready),
		.lvl      (lvl),
		.threshold(threshold_q),
		.results  (results)
	);

endmodule
